### rtl/touch_gesture_classifier_macros.svh
// Assertion macros used by the touch gesture classifier checker.
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tgc_pkg.sv
// Package with the types, codes and widths of the touch gesture classifier.
`default_nettype none

package tgc_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIST_BITS  = 12;
  localparam int HOLD_BITS  = 16;
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 4;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  localparam int MAG_W = ((COORD_BITS > DIST_BITS) ? COORD_BITS : DIST_BITS) + 1;
  localparam int SGN_W = MAG_W + 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_SWIPE_DISTANCE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_MOVE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME_MS    = 2'd2;

  localparam logic [DIST_BITS-1:0] SWIPE_DISTANCE_RST  = 12'd100;
  localparam logic [DIST_BITS-1:0] HOLD_MOVE_LIMIT_RST = 12'd30;
  localparam logic [HOLD_BITS-1:0] HOLD_TIME_MS_RST    = 16'd600;

  localparam int STATUS_DATA_BIT = 7;

  typedef enum logic [2:0] {
    G_LONG  = 3'd0,
    G_RIGHT = 3'd1,
    G_LEFT  = 3'd2,
    G_UP    = 3'd3,
    G_DOWN  = 3'd4,
    G_TAP   = 3'd5
  } gesture_t;

  typedef struct packed {
    logic [7:0]            status_byte;
    logic [COORD_BITS-1:0] touch_x;
    logic [COORD_BITS-1:0] touch_y;
    logic [TIME_BITS-1:0]  time_ms;
  } tgc_in_t;

  typedef struct packed {
    gesture_t              gesture;
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
    logic [COUNT_BITS-1:0] peak_points;
    logic [TIME_BITS-1:0]  held_ms;
  } tgc_out_t;

  typedef struct packed {
    logic [DIST_BITS-1:0] swipe_distance;
    logic [DIST_BITS-1:0] hold_move_limit;
    logic [HOLD_BITS-1:0] hold_time_ms;
  } tgc_cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [COORD_BITS-1:0] latest_x;
    logic [COORD_BITS-1:0] latest_y;
  } tgc_track_t;

endpackage

`default_nettype wire

### rtl/tgc_classify.sv
// Gesture decision from the tracked positions, contact duration and thresholds.
`default_nettype none

module tgc_classify
  import tgc_pkg::*;
(
  input  tgc_track_t           track,
  input  tgc_cfg_t             cfg,
  input  logic [TIME_BITS-1:0] held,
  output gesture_t             gesture
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]        ax_full;
  logic [COORD_BITS:0]        ay_full;
  logic [MAG_W-1:0]           ax;
  logic [MAG_W-1:0]           ay;
  logic [MAG_W-1:0]           sw;
  logic [MAG_W-1:0]           lim;
  logic signed [SGN_W-1:0]    dy_s;
  logic signed [SGN_W-1:0]    sw_s;
  logic                       is_long;
  logic                       is_horiz;
  logic                       is_up;
  logic                       is_down;

  always_comb begin
    dx = $signed({1'b0, track.latest_x}) - $signed({1'b0, track.origin_x});
    dy = $signed({1'b0, track.origin_y}) - $signed({1'b0, track.latest_y});
    ax_full = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
    ay_full = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
    ax  = MAG_W'(ax_full);
    ay  = MAG_W'(ay_full);
    sw  = MAG_W'(cfg.swipe_distance);
    lim = MAG_W'(cfg.hold_move_limit);
    dy_s = SGN_W'(dy);
    sw_s = $signed(SGN_W'(cfg.swipe_distance));

    is_long  = (held >= TIME_BITS'(cfg.hold_time_ms)) && (ax <= lim) && (ay <= lim);
    is_horiz = (ax > ay) && (ax > sw);
    is_up    = dy_s > sw_s;
    is_down  = dy_s < -sw_s;

    if (is_long) begin
      gesture = G_LONG;
    end else if (is_horiz) begin
      gesture = (!dx[COORD_BITS] && (dx != '0)) ? G_RIGHT : G_LEFT;
    end else if (is_up) begin
      gesture = G_UP;
    end else if (is_down) begin
      gesture = G_DOWN;
    end else begin
      gesture = G_TAP;
    end
  end

endmodule

`default_nettype wire

### rtl/touch_gesture_classifier.sv
// Top level of the touch gesture classifier: poll register, contact tracking, result register.
`default_nettype none

// Takes one touch-controller poll per transaction and emits one gesture transaction when a
// contact ends (long press, swipe right, left, up, down or tap) with its start and end
// coordinates, peak point count and duration. A poll is accepted every cycle unless in_stall is
// high; it is held in the poll register, and a gesture it ends is loaded from there into the
// result register, which offers it on out_data.
// A poll that ends a contact waits in the poll register while the result
// register holds an untaken gesture, and in_stall rises only then. Configuration writes are
// taken at any time but belong to idle periods; they act on the next poll that is processed.

module touch_gesture_classifier
  import tgc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tgc_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output tgc_out_t                 out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  tgc_cfg_t              cfg_r;
  logic                  poll_valid_r;
  tgc_in_t               poll_r;
  logic                  in_contact_r;
  tgc_track_t            track_r;
  logic [COUNT_BITS-1:0] most_points_r;
  logic [TIME_BITS-1:0]  start_ms_r;
  logic                  out_valid_r;
  tgc_out_t              out_r;

  logic [COUNT_BITS-1:0] count;
  logic                  contact;
  logic                  emits;
  logic                  out_free;
  logic                  process;
  logic                  accept_in;
  logic [TIME_BITS-1:0]  held;
  gesture_t              gesture;

  always_comb begin
    count     = poll_r.status_byte[COUNT_BITS-1:0];
    contact   = poll_r.status_byte[STATUS_DATA_BIT] && (count != '0);
    emits     = !contact && in_contact_r;
    out_free  = !out_valid_r || !out_stall;
    process   = poll_valid_r && (!emits || out_free);
    in_stall  = poll_valid_r && !process;
    accept_in = in_valid && !in_stall;
    held      = poll_r.time_ms - start_ms_r;
  end

  tgc_classify u_classify (
    .track   (track_r),
    .cfg     (cfg_r),
    .held    (held),
    .gesture (gesture)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_distance  <= SWIPE_DISTANCE_RST;
      cfg_r.hold_move_limit <= HOLD_MOVE_LIMIT_RST;
      cfg_r.hold_time_ms    <= HOLD_TIME_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SWIPE_DISTANCE:  cfg_r.swipe_distance  <= cfg_wdata[DIST_BITS-1:0];
        REG_HOLD_MOVE_LIMIT: cfg_r.hold_move_limit <= cfg_wdata[DIST_BITS-1:0];
        REG_HOLD_TIME_MS:    cfg_r.hold_time_ms    <= cfg_wdata[HOLD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
    end else if (accept_in) begin
      poll_valid_r <= 1'b1;
    end else if (process) begin
      poll_valid_r <= 1'b0;
    end
    if (accept_in) begin
      poll_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_contact_r  <= 1'b0;
      track_r       <= '0;
      most_points_r <= '0;
      start_ms_r    <= '0;
    end else if (process) begin
      if (contact) begin
        track_r.latest_x <= poll_r.touch_x;
        track_r.latest_y <= poll_r.touch_y;
        if (!in_contact_r) begin
          in_contact_r     <= 1'b1;
          start_ms_r       <= poll_r.time_ms;
          track_r.origin_x <= poll_r.touch_x;
          track_r.origin_y <= poll_r.touch_y;
          most_points_r    <= count;
        end else if (count > most_points_r) begin
          most_points_r <= count;
        end
      end else if (in_contact_r) begin
        in_contact_r  <= 1'b0;
        most_points_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process && emits) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (process && emits) begin
      out_r.gesture     <= gesture;
      out_r.first_x     <= track_r.origin_x;
      out_r.first_y     <= track_r.origin_y;
      out_r.last_x      <= track_r.latest_x;
      out_r.last_y      <= track_r.latest_y;
      out_r.peak_points <= most_points_r;
      out_r.held_ms     <= held;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### rtl/tgc_checker.sv
// Port-level checker for the touch gesture classifier and its bind to the top level.
`default_nettype none
`include "touch_gesture_classifier_macros.svh"

module tgc_checker
  import tgc_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire tgc_out_t out_data
);

  `TGC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "Stalled gesture transaction changed or was dropped.")
  `TGC_ASSERT_NOW(a_horiz_dir, clk, rst_n, out_valid && ((out_data.gesture == G_RIGHT) || (out_data.gesture == G_LEFT)), (out_data.gesture == G_RIGHT) ? (out_data.last_x > out_data.first_x) : (out_data.last_x < out_data.first_x), "Horizontal swipe direction disagrees with its coordinates.")
  `TGC_ASSERT_NOW(a_vert_dir, clk, rst_n, out_valid && ((out_data.gesture == G_UP) || (out_data.gesture == G_DOWN)), (out_data.gesture == G_UP) ? (out_data.first_y > out_data.last_y) : (out_data.first_y < out_data.last_y), "Vertical swipe direction disagrees with its coordinates.")
  `TGC_ASSERT_NOW(a_peak_nonzero, clk, rst_n, out_valid, out_data.peak_points != '0, "Gesture reported with a zero peak point count.")

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
